>>> src/cbc_pkg.sv
// ----------------------------------------------------------------------------
// Cartridge bank controller package
// Shared constants, widths and types of the cartridge bank controller.
// ----------------------------------------------------------------------------
package cbc_pkg;

    localparam int MAX_ROM_BANKS_DEF = 128;
    localparam int LARGE_ROM_THRESHOLD = 18;
    localparam logic [3:0] RAM_ENABLE_KEY = 4'hA;

    localparam int ADDR_W = 16;
    localparam int DATA_W = 8;
    localparam int TARGET_W = 2;
    localparam int ROM_OFF_W = 21;
    localparam int RAM_OFF_W = 15;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DATA_W = 8;
    localparam int BANK_W = 7;
    localparam int COUNT_W = 8;
    localparam int STEP_W = 3;

    localparam logic [CFG_IDX_W-1:0] CFG_ROM_BANK_COUNT = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_RAM_BANK_COUNT = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_HAS_RAM = 2'd2;

    localparam logic [TARGET_W-1:0] TGT_NONE = 2'd0;
    localparam logic [TARGET_W-1:0] TGT_ROM = 2'd1;
    localparam logic [TARGET_W-1:0] TGT_RAM = 2'd2;

    localparam logic [1:0] REG_RAM_ENABLE = 2'd0;
    localparam logic [1:0] REG_ROM_LOW = 2'd1;
    localparam logic [1:0] REG_HIGH_RAM = 2'd2;
    localparam logic [1:0] REG_MODE = 2'd3;

    typedef enum logic [1:0] {
        S_IDLE,
        S_DIV,
        S_FIN
    } t_state;

    typedef enum logic [1:0] {
        JOB_LOW,
        JOB_HIGH,
        JOB_RAM,
        JOB_WINDOW
    } t_job;

endpackage

>>> src/cbc_req_if.sv
// ----------------------------------------------------------------------------
// Bus access channel
// Carries one CPU bus access per transaction with a valid/ready handshake.
// ----------------------------------------------------------------------------
interface cbc_req_if;
    logic                          valid;
    logic                          ready;
    logic                          cmd;
    logic [cbc_pkg::ADDR_W-1:0]    addr;
    logic [cbc_pkg::DATA_W-1:0]    value;

    modport source (output valid, output cmd, output addr, output value, input ready);
    modport sink (input valid, input cmd, input addr, input value, output ready);
endinterface

>>> src/cbc_rsp_if.sv
// ----------------------------------------------------------------------------
// Mapping result channel
// Carries one mapping result per transaction with a valid/ready handshake.
// ----------------------------------------------------------------------------
interface cbc_rsp_if;
    logic                            valid;
    logic                            ready;
    logic [cbc_pkg::TARGET_W-1:0]    target;
    logic [cbc_pkg::ROM_OFF_W-1:0]   rom_offset;
    logic [cbc_pkg::RAM_OFF_W-1:0]   ram_offset;
    logic                            ram_write;
    logic [cbc_pkg::DATA_W-1:0]      write_data;

    modport source (output valid, output target, output rom_offset, output ram_offset,
                    output ram_write, output write_data, input ready);
    modport sink (input valid, input target, input rom_offset, input ram_offset,
                  input ram_write, input write_data, output ready);
endinterface

>>> src/cartridge_bank_controller.sv
// ----------------------------------------------------------------------------
// Cartridge bank controller
// Maps CPU bus accesses onto cartridge ROM and RAM offsets and keeps the
// banking registers that writes below 0x8000 program.
// ----------------------------------------------------------------------------
// An access that needs no bank reduction bypasses the remainder unit. A ROM
// bank select write, a bank-zero window read in mode 1 on a large ROM, or a
// RAM bank select write waits for the modulo by the bank count, which runs
// through one shared restoring remainder unit at one bit per cycle. A high
// bits write that updates both the ROM bank and the RAM bank uses that unit
// twice. A new transaction is accepted only while the sequencer is idle and
// the result register is empty or being drained.
module cartridge_bank_controller #(
    parameter int MAX_ROM_BANKS = cbc_pkg::MAX_ROM_BANKS_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_we,
    input  logic [cbc_pkg::CFG_IDX_W-1:0]     i_cfg_idx,
    input  logic [cbc_pkg::CFG_DATA_W-1:0]    i_cfg_data,
    cbc_req_if.sink                           i_req,
    cbc_rsp_if.source                         o_rsp
);

    localparam logic [cbc_pkg::COUNT_W-1:0] MaxBanks = cbc_pkg::COUNT_W'(MAX_ROM_BANKS);
    localparam logic [cbc_pkg::COUNT_W-1:0] LargeThr =
        cbc_pkg::COUNT_W'(cbc_pkg::LARGE_ROM_THRESHOLD);
    localparam logic [cbc_pkg::STEP_W-1:0] LastStep = cbc_pkg::STEP_W'(cbc_pkg::BANK_W - 1);

    cbc_pkg::t_state r_state, n_state;
    cbc_pkg::t_job   r_job, n_job;

    logic [cbc_pkg::STEP_W-1:0]    r_cnt, n_cnt;
    logic [cbc_pkg::BANK_W-1:0]    r_rem, n_rem;
    logic [cbc_pkg::BANK_W-1:0]    r_sh, n_sh;
    logic [cbc_pkg::BANK_W-1:0]    r_num, n_num;
    logic [cbc_pkg::COUNT_W-1:0]   r_dvsr, n_dvsr;
    logic [13:0]                   r_addr, n_addr;
    logic [1:0]                    r_sel, n_sel;

    logic                          r_ram_en, n_ram_en;
    logic [4:0]                    r_low, n_low;
    logic [1:0]                    r_high, n_high;
    logic [cbc_pkg::BANK_W-1:0]    r_cur_rom, n_cur_rom;
    logic                          r_mode, n_mode;
    logic [1:0]                    r_cur_ram, n_cur_ram;

    logic [cbc_pkg::COUNT_W-1:0]   r_rom_cnt, n_rom_cnt;
    logic [2:0]                    r_ram_cnt, n_ram_cnt;
    logic                          r_has_ram, n_has_ram;

    logic                          r_out_valid, n_out_valid;
    logic [cbc_pkg::TARGET_W-1:0]  r_target, n_target;
    logic [cbc_pkg::ROM_OFF_W-1:0] r_rom_off, n_rom_off;
    logic [cbc_pkg::RAM_OFF_W-1:0] r_ram_off, n_ram_off;
    logic                          r_ram_wr, n_ram_wr;
    logic [cbc_pkg::DATA_W-1:0]    r_wdata, n_wdata;

    logic [cbc_pkg::COUNT_W-1:0]   w_cnt_eff;
    logic                          w_large;
    logic                          w_in_fire;
    logic [cbc_pkg::COUNT_W-1:0]   w_trial;
    logic [cbc_pkg::BANK_W-1:0]    w_step_rem;
    logic [cbc_pkg::BANK_W-1:0]    w_mod;
    logic [4:0]                    w_lo;

    assign w_cnt_eff = (r_rom_cnt > MaxBanks) ? MaxBanks : r_rom_cnt;
    assign w_large   = w_cnt_eff > LargeThr;

    assign i_req.ready = (r_state == cbc_pkg::S_IDLE) && (!r_out_valid || o_rsp.ready);
    assign w_in_fire   = i_req.valid && i_req.ready;

    assign w_trial    = {r_rem, r_sh[cbc_pkg::BANK_W-1]};
    assign w_step_rem = (w_trial >= r_dvsr) ? cbc_pkg::BANK_W'(w_trial - r_dvsr)
                                            : cbc_pkg::BANK_W'(w_trial);
    assign w_mod      = (r_dvsr == '0) ? r_num : r_rem;
    assign w_lo       = (i_req.value[4:0] == 5'd0) ? 5'd1 : i_req.value[4:0];

    assign o_rsp.valid      = r_out_valid;
    assign o_rsp.target     = r_target;
    assign o_rsp.rom_offset = r_rom_off;
    assign o_rsp.ram_offset = r_ram_off;
    assign o_rsp.ram_write  = r_ram_wr;
    assign o_rsp.write_data = r_wdata;

    always_comb begin
        n_state     = r_state;
        n_job       = r_job;
        n_cnt       = r_cnt;
        n_rem       = r_rem;
        n_sh        = r_sh;
        n_num       = r_num;
        n_dvsr      = r_dvsr;
        n_addr      = r_addr;
        n_sel       = r_sel;
        n_ram_en    = r_ram_en;
        n_low       = r_low;
        n_high      = r_high;
        n_cur_rom   = r_cur_rom;
        n_mode      = r_mode;
        n_cur_ram   = r_cur_ram;
        n_rom_cnt   = r_rom_cnt;
        n_ram_cnt   = r_ram_cnt;
        n_has_ram   = r_has_ram;
        n_out_valid = r_out_valid && !o_rsp.ready;
        n_target    = r_target;
        n_rom_off   = r_rom_off;
        n_ram_off   = r_ram_off;
        n_ram_wr    = r_ram_wr;
        n_wdata     = r_wdata;

        if (i_cfg_we) begin
            unique case (i_cfg_idx)
                cbc_pkg::CFG_ROM_BANK_COUNT: n_rom_cnt = i_cfg_data;
                cbc_pkg::CFG_RAM_BANK_COUNT: n_ram_cnt = i_cfg_data[2:0];
                cbc_pkg::CFG_HAS_RAM:        n_has_ram = i_cfg_data[0];
                default: ;
            endcase
        end

        unique case (r_state)
            cbc_pkg::S_IDLE: begin
                if (w_in_fire) begin
                    n_addr    = i_req.addr[13:0];
                    n_sel     = i_req.value[1:0];
                    n_rem     = '0;
                    n_cnt     = '0;
                    n_target  = cbc_pkg::TGT_NONE;
                    n_rom_off = '0;
                    n_ram_off = '0;
                    n_ram_wr  = 1'b0;
                    n_wdata   = '0;
                    if (i_req.cmd && !i_req.addr[15]) begin
                        unique case (i_req.addr[14:13])
                            cbc_pkg::REG_RAM_ENABLE: begin
                                n_ram_en    = (i_req.value[3:0] == cbc_pkg::RAM_ENABLE_KEY);
                                n_out_valid = 1'b1;
                            end
                            cbc_pkg::REG_ROM_LOW: begin
                                n_low   = w_lo;
                                n_sh    = {r_high, w_lo};
                                n_num   = {r_high, w_lo};
                                n_dvsr  = w_cnt_eff;
                                n_job   = cbc_pkg::JOB_LOW;
                                n_state = cbc_pkg::S_DIV;
                            end
                            cbc_pkg::REG_HIGH_RAM: begin
                                if (w_large) begin
                                    n_high  = i_req.value[1:0];
                                    n_sh    = {i_req.value[1:0], r_low};
                                    n_num   = {i_req.value[1:0], r_low};
                                    n_dvsr  = w_cnt_eff;
                                    n_job   = cbc_pkg::JOB_HIGH;
                                    n_state = cbc_pkg::S_DIV;
                                end else if (r_mode && r_has_ram) begin
                                    n_sh    = {5'd0, i_req.value[1:0]};
                                    n_num   = {5'd0, i_req.value[1:0]};
                                    n_dvsr  = {5'd0, r_ram_cnt};
                                    n_job   = cbc_pkg::JOB_RAM;
                                    n_state = cbc_pkg::S_DIV;
                                end else begin
                                    n_out_valid = 1'b1;
                                end
                            end
                            cbc_pkg::REG_MODE: begin
                                n_mode = i_req.value[0];
                                if (w_large && !i_req.value[0]) begin
                                    n_cur_rom = {2'd0, r_low};
                                end
                                n_out_valid = 1'b1;
                            end
                            default: ;
                        endcase
                    end else if (i_req.addr[15:14] == 2'd0) begin
                        if (w_large && r_mode) begin
                            n_sh    = {r_high, 5'd0};
                            n_num   = {r_high, 5'd0};
                            n_dvsr  = w_cnt_eff;
                            n_job   = cbc_pkg::JOB_WINDOW;
                            n_state = cbc_pkg::S_DIV;
                        end else begin
                            n_target    = cbc_pkg::TGT_ROM;
                            n_rom_off   = {7'd0, i_req.addr[13:0]};
                            n_out_valid = 1'b1;
                        end
                    end else if (i_req.addr[15:14] == 2'd1) begin
                        n_target    = cbc_pkg::TGT_ROM;
                        n_rom_off   = {r_cur_rom, i_req.addr[13:0]};
                        n_out_valid = 1'b1;
                    end else begin
                        if (i_req.addr[15:13] == 3'b101 && r_has_ram && r_ram_en) begin
                            n_target  = cbc_pkg::TGT_RAM;
                            n_ram_off = {(r_mode ? r_cur_ram : 2'd0), i_req.addr[12:0]};
                            n_ram_wr  = i_req.cmd;
                            n_wdata   = i_req.cmd ? i_req.value : '0;
                        end
                        n_out_valid = 1'b1;
                    end
                end
            end
            cbc_pkg::S_DIV: begin
                n_rem = w_step_rem;
                n_sh  = {r_sh[cbc_pkg::BANK_W-2:0], 1'b0};
                if (r_cnt == LastStep) begin
                    n_state = cbc_pkg::S_FIN;
                end else begin
                    n_cnt = r_cnt + 1'b1;
                end
            end
            cbc_pkg::S_FIN: begin
                n_state = cbc_pkg::S_IDLE;
                unique case (r_job)
                    cbc_pkg::JOB_LOW: begin
                        n_cur_rom   = w_mod;
                        n_out_valid = 1'b1;
                    end
                    cbc_pkg::JOB_HIGH: begin
                        n_cur_rom = w_mod;
                        if (r_mode && r_has_ram) begin
                            n_rem   = '0;
                            n_cnt   = '0;
                            n_sh    = {5'd0, r_sel};
                            n_num   = {5'd0, r_sel};
                            n_dvsr  = {5'd0, r_ram_cnt};
                            n_job   = cbc_pkg::JOB_RAM;
                            n_state = cbc_pkg::S_DIV;
                        end else begin
                            n_out_valid = 1'b1;
                        end
                    end
                    cbc_pkg::JOB_RAM: begin
                        n_cur_ram   = w_mod[1:0];
                        n_out_valid = 1'b1;
                    end
                    cbc_pkg::JOB_WINDOW: begin
                        n_target    = cbc_pkg::TGT_ROM;
                        n_rom_off   = {w_mod, r_addr};
                        n_out_valid = 1'b1;
                    end
                    default: ;
                endcase
            end
            default: n_state = cbc_pkg::S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= cbc_pkg::S_IDLE;
            r_job       <= cbc_pkg::JOB_LOW;
            r_cnt       <= '0;
            r_ram_en    <= 1'b0;
            r_low       <= 5'd1;
            r_high      <= 2'd0;
            r_cur_rom   <= 7'd1;
            r_mode      <= 1'b0;
            r_cur_ram   <= 2'd0;
            r_rom_cnt   <= 8'd2;
            r_ram_cnt   <= 3'd1;
            r_has_ram   <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_job       <= n_job;
            r_cnt       <= n_cnt;
            r_ram_en    <= n_ram_en;
            r_low       <= n_low;
            r_high      <= n_high;
            r_cur_rom   <= n_cur_rom;
            r_mode      <= n_mode;
            r_cur_ram   <= n_cur_ram;
            r_rom_cnt   <= n_rom_cnt;
            r_ram_cnt   <= n_ram_cnt;
            r_has_ram   <= n_has_ram;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rem     <= n_rem;
        r_sh      <= n_sh;
        r_num     <= n_num;
        r_dvsr    <= n_dvsr;
        r_addr    <= n_addr;
        r_sel     <= n_sel;
        r_target  <= n_target;
        r_rom_off <= n_rom_off;
        r_ram_off <= n_ram_off;
        r_ram_wr  <= n_ram_wr;
        r_wdata   <= n_wdata;
    end

endmodule
